// ===== src/bits_pkg.sv =====
// ============================================================================
// bits_pkg
// Shared types and constants for the best incoming transition select core.
// ============================================================================
package bits_pkg;

   localparam int MAX_EMIT_LEN = 15;
   localparam int SCORE_BITS   = 32;
   localparam int SAT_BITS     = (SCORE_BITS < 32) ? SCORE_BITS : 32;

   // minus infinity, fixed at the 32-bit most negative code
   localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
   localparam logic signed [32:0] SAT_HI  = 33'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] SAT_LO  = 33'(-((64'sd1 <<< (SAT_BITS - 1))));
   localparam logic [7:0]         LEN_CAP = 8'(MAX_EMIT_LEN);

   typedef enum logic [1:0] {
      MODE_ALL         = 2'd0,
      MODE_SKIP_SILENT = 2'd1,
      MODE_ROW_ZERO    = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [15:0]        row;
      logic [9:0]         dest_state;
      logic [9:0]         source_state;
      logic [7:0]         trans_index;
      logic [3:0]         span_min;
      logic [3:0]         span_max;
      logic [3:0]         emit_len;
      logic signed [31:0] prev_score;
      logic signed [31:0] trans_score;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] best_score;
      logic [9:0]         best_source;
      logic [7:0]         best_tr_index;
      logic [3:0]         best_len_offset;
      logic               found;
   } rsp_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] score;
      logic [3:0]         len_offset;
   } eval_type;

endpackage

// ===== src/bits_acs_eval.sv =====
// ============================================================================
// bits_acs_eval
// Candidate filter and saturating score add for one candidate.
// ============================================================================
module bits_acs_eval
   import bits_pkg::*;
(
   input  req_type  cand,
   output eval_type eval
);

   logic              len_ok;
   logic              pass;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;

   // span clipped to row and to the longest supported length
   assign len_ok = (cand.emit_len >= cand.span_min) &&
                   (cand.emit_len <= cand.span_max) &&
                   ({12'd0, cand.emit_len} <= cand.row) &&
                   ({4'd0, cand.emit_len} <= LEN_CAP) &&
                   ({12'd0, cand.span_min} <= cand.row);

   always_comb begin
      case (cand.mode)
         MODE_ALL:         pass = len_ok;
         MODE_SKIP_SILENT: pass = len_ok && (cand.span_min != 4'd0);
         MODE_ROW_ZERO:    pass = (cand.span_min == 4'd0) &&
                                  (cand.source_state <= cand.dest_state) &&
                                  (cand.emit_len == 4'd0);
         default:          pass = 1'b0;
      endcase
   end

   assign sum_wide = {cand.prev_score[31], cand.prev_score} +
                     {cand.trans_score[31], cand.trans_score};

   always_comb begin
      if ((cand.prev_score == NEG_INF) || (cand.trans_score == NEG_INF)) begin
         sum_sat = NEG_INF;
      end else if (sum_wide > SAT_HI) begin
         sum_sat = SAT_HI[31:0];
      end else if (sum_wide < SAT_LO) begin
         sum_sat = SAT_LO[31:0];
      end else begin
         sum_sat = sum_wide[31:0];
      end
   end

   assign eval.ok         = pass;
   assign eval.score      = sum_sat;
   assign eval.len_offset = (cand.mode == MODE_ROW_ZERO) ? 4'd0
                                                        : cand.emit_len - cand.span_min;

endmodule

// ===== src/best_incoming_transition_select_core.sv =====
// ============================================================================
// best_incoming_transition_select_core
// Viterbi add-compare-select over a candidate stream; one result per query.
// ============================================================================
//  channel  dir   handshake                payload
//  req      in    req_valid / req_stall    req_data  (req_type)
//  rsp      out   rsp_valid / rsp_stall    rsp_data  (rsp_type)
//
//  One candidate transfer per cycle; the filter, saturating add and compare
//  against the running best sit between the input stage and the result
//  register, which takes each query's best when its last candidate fires.
//  Synchronous reset clears the stage valids and the running best.
//  Only a last candidate waiting on a held result stalls the input.
// ============================================================================
module best_incoming_transition_select_core
   import bits_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_data_ff;
   logic               s1_fire;
   logic               req_fire;
   eval_type           ev;
   logic               better;

   logic signed [31:0] run_score_ff, run_score_in;
   logic [9:0]         run_source_ff, run_source_in;
   logic [7:0]         run_trans_ff, run_trans_in;
   logic [3:0]         run_len_ff, run_len_in;
   logic               run_found_ff, run_found_in;

   rsp_type            cur;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   bits_acs_eval u_eval (
      .cand (s1_data_ff),
      .eval (ev)
   );

   assign s1_fire   = s1_valid_ff && !(s1_data_ff.last && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;

   // strict greater: a tie keeps the earlier candidate
   assign better = ev.ok && (ev.score > run_score_ff);

   always_comb begin
      if (better) begin
         cur.best_score      = ev.score;
         cur.best_source     = s1_data_ff.source_state;
         cur.best_tr_index   = s1_data_ff.trans_index;
         cur.best_len_offset = ev.len_offset;
         cur.found           = 1'b1;
      end else begin
         cur.best_score      = run_score_ff;
         cur.best_source     = run_source_ff;
         cur.best_tr_index   = run_trans_ff;
         cur.best_len_offset = run_len_ff;
         cur.found           = run_found_ff;
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      run_score_in  = run_score_ff;
      run_source_in = run_source_ff;
      run_trans_in  = run_trans_ff;
      run_len_in    = run_len_ff;
      run_found_in  = run_found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      if (s1_fire) begin
         if (s1_data_ff.last) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = cur;
            run_score_in  = NEG_INF;
            run_source_in = 10'd0;
            run_trans_in  = 8'd0;
            run_len_in    = 4'd0;
            run_found_in  = 1'b0;
         end else begin
            run_score_in  = cur.best_score;
            run_source_in = cur.best_source;
            run_trans_in  = cur.best_tr_index;
            run_len_in    = cur.best_len_offset;
            run_found_in  = cur.found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         run_score_ff  <= NEG_INF;
         run_source_ff <= 10'd0;
         run_trans_ff  <= 8'd0;
         run_len_ff    <= 4'd0;
         run_found_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         run_score_ff  <= run_score_in;
         run_source_ff <= run_source_in;
         run_trans_ff  <= run_trans_in;
         run_len_ff    <= run_len_in;
         run_found_ff  <= run_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no winner yet means the running score is still minus infinity
   a_run_empty: assert property (@(posedge clock) disable iff (reset)
      !run_found_ff |-> (run_score_ff == NEG_INF))
      else $error("running best holds a score without a winner");

   a_found_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> (rsp_data.best_score != NEG_INF))
      else $error("found result carries minus infinity");

   a_query_clear: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_data_ff.last |=> !run_found_ff && rsp_valid)
      else $error("query end did not clear running best or post a result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_data_ff.last && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

endmodule

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Testbench for the best incoming transition select core. A queue of
// candidate queries (directed corner cases, then random queries) feeds a
// bursty driver. An add-compare-select predictor updates on every input
// transfer and queues one expected result per query. A monitor behind a
// stalling receiver compares each result transfer field by field.
// ============================================================================
module tb_top;
   import bits_pkg::*;

   localparam logic [1:0]         MODE_UNUSED = 2'd3;
   localparam logic signed [31:0] SCORE_TOP   = 32'sh7FFF_FFFF;
   localparam logic signed [32:0] SUM_TOP     = 33'sh0_7FFF_FFFF;
   localparam logic signed [32:0] SUM_BOTTOM  = -33'sh0_8000_0000;
   localparam int                 RANDOM_ITEMS = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_candidates[$];
   rsp_type expected_best[$];
   int      mismatches = 0;
   int      burst_left = 1;
   int      gap_left = 0;
   int      stall_style = 0;
   int      stall_cycles = 0;

   // running best of the query in flight
   logic signed [31:0] acs_score = NEG_INF;
   logic [9:0]         acs_source = '0;
   logic [7:0]         acs_trans = '0;
   logic [3:0]         acs_offset = '0;
   logic               acs_found = 1'b0;

   best_incoming_transition_select_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial forever #2 clock = ~clock;

   function automatic logic signed [31:0] saturated_sum(logic signed [31:0] a,
                                                         logic signed [31:0] b);
      logic signed [32:0] s;
      if (a == NEG_INF || b == NEG_INF) return NEG_INF;
      s = $signed({a[31], a}) + $signed({b[31], b});
      if (s > SUM_TOP) return SCORE_TOP;
      if (s < SUM_BOTTOM) return NEG_INF;
      return s[31:0];
   endfunction

   task automatic absorb_candidate(input req_type c);
      int unsigned top;
      logic        ok;
      logic [3:0]  offset;
      logic signed [31:0] score;
      ok = 1'b0;
      offset = '0;
      case (c.mode)
         MODE_ALL, MODE_SKIP_SILENT: begin
            top = c.span_max;
            if (c.row < top) top = c.row;
            if (top > MAX_EMIT_LEN) top = MAX_EMIT_LEN;
            ok = (c.row >= c.span_min) && (c.emit_len >= c.span_min) && (c.emit_len <= top);
            if (c.mode == MODE_SKIP_SILENT && c.span_min == 0) ok = 1'b0;
            if (ok) offset = c.emit_len - c.span_min;
         end
         MODE_ROW_ZERO: begin
            ok = (c.span_min == 0) && (c.source_state <= c.dest_state) && (c.emit_len == 0);
         end
         default: ok = 1'b0;
      endcase
      if (ok) begin
         score = saturated_sum(c.prev_score, c.trans_score);
         if (score > acs_score) begin
            acs_score = score;
            acs_source = c.source_state;
            acs_trans = c.trans_index;
            acs_offset = offset;
            acs_found = 1'b1;
         end
      end
      if (c.last) begin
         expected_best.push_back({acs_score, acs_source, acs_trans, acs_offset, acs_found});
         acs_score = NEG_INF;
         acs_source = '0;
         acs_trans = '0;
         acs_offset = '0;
         acs_found = 1'b0;
      end
   endtask

   function automatic req_type make_candidate(logic [1:0] mode, logic [15:0] row,
                                              logic [9:0] dst, logic [9:0] src,
                                              logic [7:0] tr, logic [3:0] smin,
                                              logic [3:0] smax, logic [3:0] len,
                                              logic signed [31:0] prev,
                                              logic signed [31:0] ts, logic last);
      req_type c;
      c.mode = mode_type'(mode);
      c.row = row;
      c.dest_state = dst;
      c.source_state = src;
      c.trans_index = tr;
      c.span_min = smin;
      c.span_max = smax;
      c.emit_len = len;
      c.prev_score = prev;
      c.trans_score = ts;
      c.last = last;
      return c;
   endfunction

   function automatic logic signed [31:0] random_score();
      case ($urandom_range(0, 9))
         0: return NEG_INF;
         1: return SCORE_TOP;
         2: return NEG_INF + 32'sd1;
         3: return $urandom;
         4: return SCORE_TOP - 32'($urandom_range(0, 1000));
         5: return NEG_INF + 32'($urandom_range(1, 1000));
         default: return 32'($urandom_range(0, 2 * 1048576)) - 32'sd1048576;
      endcase
   endfunction

   function automatic req_type random_candidate(logic last);
      req_type    c;
      logic [3:0] lo;
      logic [3:0] hi;
      int         pick;
      c.row = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
      c.dest_state = 10'($urandom);
      c.source_state = 10'($urandom);
      c.trans_index = 8'($urandom);
      c.prev_score = random_score();
      c.trans_score = random_score();
      c.last = last;
      pick = $urandom_range(0, 19);
      if (pick < 8) c.mode = MODE_ALL;
      else if (pick < 13) c.mode = MODE_SKIP_SILENT;
      else if (pick < 18) c.mode = MODE_ROW_ZERO;
      else c.mode = mode_type'(MODE_UNUSED);
      if (c.mode == MODE_ROW_ZERO) begin
         c.span_min = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd0;
         c.span_max = 4'($urandom);
         c.emit_len = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd0;
         if ($urandom_range(0, 4) != 0 && c.source_state > c.dest_state)
            c.source_state = 10'($urandom_range(0, c.dest_state));
      end else begin
         lo = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
         hi = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(lo, 15));
         c.span_min = lo;
         c.span_max = hi;
         c.emit_len = (hi >= lo && $urandom_range(0, 4) != 0) ?
                      4'($urandom_range(lo, hi)) : 4'($urandom);
      end
      return c;
   endfunction

   // driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) absorb_candidate(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_candidates.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_candidates.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: the stall style changes every so often
   always @(posedge clock) begin
      if (stall_cycles == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_cycles = $urandom_range(20, 120);
      end else begin
         stall_cycles--;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= (stall_cycles % 5 < 2);
      endcase
   end

   // monitor: score/source/trans/offset/found
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_best.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: %0d/%0d/%0d/%0d/%0b",
                        rsp_data.best_score, rsp_data.best_source, rsp_data.best_tr_index,
                        rsp_data.best_len_offset, rsp_data.found);
         end else begin
            want = expected_best.pop_front();
            if (rsp_data.best_score !== want.best_score ||
                rsp_data.best_source !== want.best_source ||
                rsp_data.best_tr_index !== want.best_tr_index ||
                rsp_data.best_len_offset !== want.best_len_offset ||
                rsp_data.found !== want.found) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                           want.best_score, want.best_source, want.best_tr_index,
                           want.best_len_offset, want.found,
                           rsp_data.best_score, rsp_data.best_source, rsp_data.best_tr_index,
                           rsp_data.best_len_offset, rsp_data.found);
            end
         end
      end
   end

   initial begin
      int items;
      int qlen;
      // tie keeps first; out-of-span and row below span minimum are skipped
      pending_candidates.push_back(make_candidate(MODE_ALL, 100, 5, 3, 10, 2, 5, 2, 100, 50, 0));
      pending_candidates.push_back(make_candidate(MODE_ALL, 100, 5, 4, 11, 2, 5, 5, 120, 30, 0));
      pending_candidates.push_back(make_candidate(MODE_ALL, 100, 5, 6, 12, 2, 5, 6,
                                                  SCORE_TOP, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ALL, 100, 5, 7, 13, 2, 5, 1,
                                                  SCORE_TOP, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ALL, 1, 5, 8, 14, 3, 5, 3,
                                                  SCORE_TOP, 0, 1));
      // saturation both ways, minus infinity operands
      pending_candidates.push_back(make_candidate(MODE_ALL, 16'hFFFF, 1023, 1023, 255, 0, 15, 15,
                                                  SCORE_TOP, SCORE_TOP, 1));
      pending_candidates.push_back(make_candidate(MODE_ALL, 10, 0, 0, 0, 1, 3, 1,
                                                  NEG_INF + 32'sd1, -32'sd5, 1));
      pending_candidates.push_back(make_candidate(MODE_ALL, 10, 0, 1, 1, 0, 3, 0,
                                                  NEG_INF, 1000, 0));
      pending_candidates.push_back(make_candidate(MODE_ALL, 10, 0, 2, 2, 0, 3, 0,
                                                  1000, NEG_INF, 1));
      // skip silent-capable sources
      pending_candidates.push_back(make_candidate(MODE_SKIP_SILENT, 10, 0, 3, 3, 0, 3, 1,
                                                  500, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_SKIP_SILENT, 10, 0, 4, 4, 1, 3, 3,
                                                  -500, 0, 1));
      // row zero: silent sources with src not above dst, length zero
      pending_candidates.push_back(make_candidate(MODE_ROW_ZERO, 0, 5, 5, 1, 0, 4, 0,
                                                  -100, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ROW_ZERO, 0, 5, 6, 2, 0, 4, 0,
                                                  100, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ROW_ZERO, 0, 5, 2, 3, 1, 4, 0,
                                                  100, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ROW_ZERO, 0, 5, 2, 4, 0, 4, 1,
                                                  100, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ROW_ZERO, 900, 5, 0, 5, 0, 0, 0,
                                                  7, 0, 1));
      // unused mode, empty span, row clipping the span
      pending_candidates.push_back(make_candidate(MODE_UNUSED, 100, 5, 1, 1, 0, 5, 2,
                                                  100, 0, 1));
      pending_candidates.push_back(make_candidate(MODE_ALL, 100, 5, 1, 1, 6, 3, 4, 100, 0, 1));
      pending_candidates.push_back(make_candidate(MODE_ALL, 3, 5, 1, 1, 0, 10, 4, 100, 0, 0));
      pending_candidates.push_back(make_candidate(MODE_ALL, 3, 5, 2, 2, 0, 10, 3, -2000, 0, 1));
      pending_candidates.push_back(make_candidate(MODE_ALL, 16'hFFFF, 1023, 1023, 255, 15, 15, 15,
                                                  0, 0, 1));
      pending_candidates.push_back(make_candidate(MODE_ALL, 20, 1023, 512, 128, 0, 15, 0,
                                                  NEG_INF + 32'sd1, 0, 1));
      items = 0;
      while (items < RANDOM_ITEMS) begin
         qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         for (int i = 0; i < qlen; i++)
            pending_candidates.push_back(random_candidate(i == qlen - 1));
         items += qlen;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_candidates.size() > 0 || req_valid) @(posedge clock);
      while (expected_best.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_best.size() == 0) begin
         $display("** best_incoming_transition_select_core: PASSED **");
      end else begin
         $display("** best_incoming_transition_select_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** best_incoming_transition_select_core: FAILED **");
      $finish;
   end

endmodule
